/* rtl/core/rmq_pkg.sv */
// Shared constants and pipeline stage types for the rotation matrix to quaternion unit.
package rmq_pkg;

  localparam int FRAC_BITS = 30;
  localparam int QW        = FRAC_BITS + 1;   // quotient width, holds one
  localparam int NW        = FRAC_BITS + 32;  // dividend width
  localparam int VW        = 35;              // branch vector width
  localparam int MW        = 31;              // normalized magnitude width
  localparam int SQ_STEPS  = 32;
  localparam int POS_SHIFT = 38;

  localparam logic [QW-1:0]        ONE_Q     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [VW-1:0] ONE_V     = VW'(ONE_Q);
  // ceil(2^38 / 1000); exact floor division by 1000 for every 32-bit dividend.
  localparam logic [28:0]          POS_RECIP = 29'd274877907;
  localparam logic [31:0]          POS_BIAS  = 32'd500;

  typedef struct packed {
    logic [3:0][MW-1:0]            m;
    logic [3:0]                    neg;
    logic                          zero;
    logic [63:0]                   rem;
    logic [63:0]                   res;
    logic [2:0][31:0]              pq;
    logic [2:0]                    pneg;
  } sq_stage_t;

  typedef struct packed {
    logic [3:0][32:0]   rem;
    logic [3:0][QW-1:0] lo;
    logic [31:0]        n;
    logic [3:0]         neg;
    logic               zero;
    logic [2:0][31:0]   pos;
  } dv_stage_t;

endpackage

/* rtl/core/rotation_matrix_to_quaternion_unit.sv */
// Top level: pipelined rotation matrix and translation to pose converter.
// Takes one transform per cycle while not stalled and returns one pose per item through
// seven setup stages, a square-root entry register and 32 square-root stages,
// one divisor stage, 31 divide stages and the output register. The quaternion follows
// Shepperd's branch choice and is normalized with a bit-per-stage square root and four
// bit-per-stage dividers; the position is the translation divided by 1000 through a
// reciprocal multiply, rounded half away from zero. The whole pipeline holds while
// out_stall is high and an item waits at the output.
module rotation_matrix_to_quaternion_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_r00,
  input  logic signed [31:0] in_r01,
  input  logic signed [31:0] in_r02,
  input  logic signed [31:0] in_r10,
  input  logic signed [31:0] in_r11,
  input  logic signed [31:0] in_r12,
  input  logic signed [31:0] in_r20,
  input  logic signed [31:0] in_r21,
  input  logic signed [31:0] in_r22,
  input  logic signed [31:0] in_tx_mm,
  input  logic signed [31:0] in_ty_mm,
  input  logic signed [31:0] in_tz_mm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_quat_w
);
  import rmq_pkg::*;

  logic adv;
  logic [6:0] early_vld_r;
  logic [SQ_STEPS:0] sq_vld_r;
  logic [QW:0] dv_vld_r;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign out_valid = out_valid_r;

  // Stage 1: branch selection and translation magnitudes.
  logic signed [VW-1:0] s1_v_nxt [4];
  logic [31:0]          s1_pmag_nxt [3];
  logic [2:0]           s1_pneg_nxt;
  logic signed [VW-1:0] s1_v_r [4];
  logic [31:0]          s1_pmag_r [3];
  logic [2:0]           s1_pneg_r;

  always_comb begin
    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, tr;
    logic signed [31:0] tin [3];
    e00 = VW'(in_r00); e01 = VW'(in_r01); e02 = VW'(in_r02);
    e10 = VW'(in_r10); e11 = VW'(in_r11); e12 = VW'(in_r12);
    e20 = VW'(in_r20); e21 = VW'(in_r21); e22 = VW'(in_r22);
    tr = e00 + e11 + e22;
    if (tr > 0) begin
      s1_v_nxt[0] = tr + ONE_V;
      s1_v_nxt[1] = e21 - e12;
      s1_v_nxt[2] = e02 - e20;
      s1_v_nxt[3] = e10 - e01;
    end else if (in_r00 > in_r11 && in_r00 > in_r22) begin
      s1_v_nxt[0] = e21 - e12;
      s1_v_nxt[1] = ONE_V + e00 - e11 - e22;
      s1_v_nxt[2] = e01 + e10;
      s1_v_nxt[3] = e02 + e20;
    end else if (in_r11 > in_r22) begin
      s1_v_nxt[0] = e02 - e20;
      s1_v_nxt[1] = e01 + e10;
      s1_v_nxt[2] = ONE_V + e11 - e00 - e22;
      s1_v_nxt[3] = e12 + e21;
    end else begin
      s1_v_nxt[0] = e10 - e01;
      s1_v_nxt[1] = e02 + e20;
      s1_v_nxt[2] = e12 + e21;
      s1_v_nxt[3] = ONE_V + e22 - e00 - e11;
    end
    tin[0] = in_tx_mm;
    tin[1] = in_ty_mm;
    tin[2] = in_tz_mm;
    for (int i = 0; i < 3; i++) begin
      s1_pneg_nxt[i] = tin[i][31];
      s1_pmag_nxt[i] = (tin[i][31] ? (~tin[i] + 32'd1) : tin[i]) + POS_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v_r    <= s1_v_nxt;
      s1_pmag_r <= s1_pmag_nxt;
      s1_pneg_r <= s1_pneg_nxt;
    end
  end

  // Stage 2: magnitudes and their maximum.
  // From here on the position fields hold the rounded magnitude divided by 1000.
  logic [VW-1:0] s2_m_r [4];
  logic [VW-1:0] s2_mx_r;
  logic [3:0]    s2_neg_r;
  logic [31:0]   s2_pmag_r [3];
  logic [2:0]    s2_pneg_r;
  logic [VW-1:0] s2_m_nxt [4];
  logic [VW-1:0] s2_mx_nxt;
  logic [31:0]   s2_pmag_nxt [3];

  always_comb begin
    logic [VW-1:0] a, b;
    logic [60:0]   prod;
    for (int i = 0; i < 4; i++) begin
      s2_m_nxt[i] = s1_v_r[i][VW-1] ? VW'(-s1_v_r[i]) : VW'(s1_v_r[i]);
    end
    a = (s2_m_nxt[0] > s2_m_nxt[1]) ? s2_m_nxt[0] : s2_m_nxt[1];
    b = (s2_m_nxt[2] > s2_m_nxt[3]) ? s2_m_nxt[2] : s2_m_nxt[3];
    s2_mx_nxt = (a > b) ? a : b;
    for (int i = 0; i < 3; i++) begin
      prod = 61'(s1_pmag_r[i]) * 61'(POS_RECIP);
      s2_pmag_nxt[i] = 32'(prod >> POS_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_m_r  <= s2_m_nxt;
      s2_mx_r <= s2_mx_nxt;
      for (int i = 0; i < 4; i++) begin
        s2_neg_r[i] <= s1_v_r[i][VW-1];
      end
      s2_pmag_r <= s2_pmag_nxt;
      s2_pneg_r <= s1_pneg_r;
    end
  end

  // Stage 3: position of the leading one of the maximum.
  logic [VW-1:0] s3_m_r [4];
  logic [5:0]    s3_msb_r;
  logic [3:0]    s3_neg_r;
  logic          s3_zero_r;
  logic [31:0]   s3_pmag_r [3];
  logic [2:0]    s3_pneg_r;
  logic [5:0]    s3_msb_nxt;

  always_comb begin
    s3_msb_nxt = '0;
    for (int i = 0; i < VW; i++) begin
      if (s2_mx_r[i]) s3_msb_nxt = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_m_r    <= s2_m_r;
      s3_msb_r  <= s3_msb_nxt;
      s3_neg_r  <= s2_neg_r;
      s3_zero_r <= (s2_mx_r == '0);
      s3_pmag_r <= s2_pmag_r;
      s3_pneg_r <= s2_pneg_r;
    end
  end

  // Stage 4: common shift that puts the maximum in [2^30, 2^31).
  logic [MW-1:0] s4_m_r [4];
  logic [3:0]    s4_neg_r;
  logic          s4_zero_r;
  logic [31:0]   s4_pmag_r [3];
  logic [2:0]    s4_pneg_r;
  logic [MW-1:0] s4_m_nxt [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s3_msb_r > 6'd30) begin
        s4_m_nxt[i] = MW'(s3_m_r[i] >> (s3_msb_r - 6'd30));
      end else begin
        s4_m_nxt[i] = MW'(s3_m_r[i] << (6'd30 - s3_msb_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_m_r    <= s4_m_nxt;
      s4_neg_r  <= s3_neg_r;
      s4_zero_r <= s3_zero_r;
      s4_pmag_r <= s3_pmag_r;
      s4_pneg_r <= s3_pneg_r;
    end
  end

  // Stages 5 to 7: squares and their sum.
  logic [2*MW-1:0] s5_sq_r [4];
  logic [2*MW:0]   s6_p_r [2];
  logic [63:0]     s7_sum_r;
  logic [MW-1:0]   s5_m_r [4], s6_m_r [4], s7_m_r [4];
  logic [3:0]      s5_neg_r, s6_neg_r, s7_neg_r;
  logic            s5_zero_r, s6_zero_r, s7_zero_r;
  logic [31:0]     s5_pmag_r [3], s6_pmag_r [3], s7_pmag_r [3];
  logic [2:0]      s5_pneg_r, s6_pneg_r, s7_pneg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s5_sq_r[i] <= (2*MW)'(s4_m_r[i]) * (2*MW)'(s4_m_r[i]);
      end
      s6_p_r[0] <= (2*MW+1)'(s5_sq_r[0]) + (2*MW+1)'(s5_sq_r[1]);
      s6_p_r[1] <= (2*MW+1)'(s5_sq_r[2]) + (2*MW+1)'(s5_sq_r[3]);
      s7_sum_r  <= 64'(s6_p_r[0]) + 64'(s6_p_r[1]);
      s5_m_r <= s4_m_r;  s6_m_r <= s5_m_r;  s7_m_r <= s6_m_r;
      s5_neg_r <= s4_neg_r;  s6_neg_r <= s5_neg_r;  s7_neg_r <= s6_neg_r;
      s5_zero_r <= s4_zero_r;  s6_zero_r <= s5_zero_r;  s7_zero_r <= s6_zero_r;
      s5_pmag_r <= s4_pmag_r;  s6_pmag_r <= s5_pmag_r;  s7_pmag_r <= s6_pmag_r;
      s5_pneg_r <= s4_pneg_r;  s6_pneg_r <= s5_pneg_r;  s7_pneg_r <= s6_pneg_r;
    end
  end

  // Square root, one result bit per stage; the position quotients ride along.
  sq_stage_t sq_r   [SQ_STEPS+1];
  sq_stage_t sq_nxt [SQ_STEPS];
  sq_stage_t sq_head;

  always_comb begin
    sq_head = '0;
    for (int i = 0; i < 4; i++) begin
      sq_head.m[i] = s7_m_r[i];
    end
    sq_head.neg  = s7_neg_r;
    sq_head.zero = s7_zero_r;
    sq_head.rem  = s7_sum_r;
    sq_head.res  = '0;
    for (int i = 0; i < 3; i++) begin
      sq_head.pq[i] = s7_pmag_r[i];
    end
    sq_head.pneg = s7_pneg_r;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    always_comb begin
      logic [64:0] trial;
      sq_nxt[k] = sq_r[k];
      trial = 65'(sq_r[k].res) + 65'(BIT);
      if (65'(sq_r[k].rem) >= trial) begin
        sq_nxt[k].rem = sq_r[k].rem - 64'(trial);
        sq_nxt[k].res = (sq_r[k].res >> 1) + BIT;
      end else begin
        sq_nxt[k].res = sq_r[k].res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= sq_head;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_r[k+1] <= sq_nxt[k];
      end
    end
  end

  // Divisor stage: forms the rounded dividends and the signed positions.
  dv_stage_t dv_r   [QW+1];
  dv_stage_t dv_nxt [QW];
  dv_stage_t dv_head;

  always_comb begin
    logic [31:0]   nd;
    logic [NW-1:0] num;
    sq_stage_t     sl;
    sl = sq_r[SQ_STEPS];
    nd = (sl.res[31:0] == '0) ? 32'd1 : sl.res[31:0];
    dv_head = '0;
    dv_head.n    = nd;
    dv_head.neg  = sl.neg;
    dv_head.zero = sl.zero;
    for (int i = 0; i < 4; i++) begin
      num = (NW'(sl.m[i]) << FRAC_BITS) + NW'(nd >> 1);
      dv_head.rem[i] = 33'(num >> QW);
      dv_head.lo[i]  = num[QW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      dv_head.pos[i] = sl.pneg[i] ? (32'd0 - sl.pq[i]) : sl.pq[i];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_comb begin
      logic [32:0] dt;
      dv_nxt[k] = dv_r[k];
      for (int i = 0; i < 4; i++) begin
        dt = {dv_r[k].rem[i][31:0], dv_r[k].lo[i][QW-1]};
        if (dt >= {1'b0, dv_r[k].n}) begin
          dv_nxt[k].rem[i] = dt - {1'b0, dv_r[k].n};
          dv_nxt[k].lo[i]  = {dv_r[k].lo[i][QW-2:0], 1'b1};
        end else begin
          dv_nxt[k].rem[i] = dt;
          dv_nxt[k].lo[i]  = {dv_r[k].lo[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv_head;
      for (int k = 0; k < QW; k++) begin
        dv_r[k+1] <= dv_nxt[k];
      end
    end
  end

  // Output register: clamp, restore signs, and map the all-zero case to identity.
  logic [31:0] quat_nxt [4];
  logic [31:0] quat_r [4];
  logic [31:0] pos_r [3];

  always_comb begin
    logic [QW-1:0] q;
    for (int i = 0; i < 4; i++) begin
      q = (dv_r[QW].lo[i] > ONE_Q) ? ONE_Q : dv_r[QW].lo[i];
      quat_nxt[i] = dv_r[QW].neg[i] ? (32'd0 - 32'(q)) : 32'(q);
      if (dv_r[QW].zero) quat_nxt[i] = (i == 0) ? 32'(ONE_Q) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat_r <= quat_nxt;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= dv_r[QW].pos[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      early_vld_r <= '0;
      sq_vld_r    <= '0;
      dv_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      early_vld_r <= {early_vld_r[5:0], in_valid};
      sq_vld_r    <= {sq_vld_r[SQ_STEPS-1:0], early_vld_r[6]};
      dv_vld_r    <= {dv_vld_r[QW-1:0], sq_vld_r[SQ_STEPS]};
      out_valid_r <= dv_vld_r[QW];
    end
  end

  assign out_pos_x  = pos_r[0];
  assign out_pos_y  = pos_r[1];
  assign out_pos_z  = pos_r[2];
  assign out_quat_w = quat_r[0];
  assign out_quat_x = quat_r[1];
  assign out_quat_y = quat_r[2];
  assign out_quat_z = quat_r[3];

  // A nonzero vector is normalized so that the sum of squares is at least 2^60.
  a_norm_sum: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld_r[0] && !sq_r[0].zero |-> sq_r[0].rem >= (64'd1 << 60))
    else $error("normalized sum of squares below range");

  // The square root of that sum is at least 2^30, so the divisor is never small.
  a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[0] && !dv_r[0].zero |-> dv_r[0].n >= (32'd1 << FRAC_BITS))
    else $error("divisor below range");

  // A held pipeline keeps its valid bits.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sq_vld_r) && $stable(dv_vld_r))
    else $error("pipeline moved while stalled");

  // The scalar part never exceeds one in magnitude.
  a_quat_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_w <= $signed(32'(ONE_Q))) && (out_quat_w >= -$signed(32'(ONE_Q))))
    else $error("quaternion component out of range");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the rotation matrix to quaternion unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE_SHIFT  = rmq_pkg::FRAC_BITS;
  localparam int N_RANDOM   = 1030;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 200;

  typedef struct {
    logic signed [31:0] rot [9];
    logic signed [31:0] trans [3];
  } transform_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] quat [4];  // x, y, z, w
  } pose_t;

  // Fixed-point Shepperd conversion of one transform to the expected pose.
  function automatic pose_t pose_of(transform_t tf);
    pose_t p;
    longint signed r [9];
    longint signed vec [4];
    longint signed trace, one_l;
    longint unsigned mag [4];
    longint unsigned top, acc, root, rbit, rem_x, q, mm;
    one_l = longint'(1) << ONE_SHIFT;
    for (int i = 0; i < 3; i++) begin
      mm = (tf.trans[i] < 0) ? longint'(-longint'(tf.trans[i])) : longint'(tf.trans[i]);
      q = (mm + 500) / 1000;
      p.pos[i] = (tf.trans[i] < 0) ? 32'(-longint'(q)) : 32'(q);
    end
    for (int i = 0; i < 9; i++) r[i] = tf.rot[i];
    trace = r[0] + r[4] + r[8];
    if (trace > 0) begin
      vec = '{trace + one_l, r[7] - r[5], r[2] - r[6], r[3] - r[1]};
    end else if (r[0] > r[4] && r[0] > r[8]) begin
      vec = '{r[7] - r[5], one_l + r[0] - r[4] - r[8], r[1] + r[3], r[2] + r[6]};
    end else if (r[4] > r[8]) begin
      vec = '{r[2] - r[6], r[1] + r[3], one_l + r[4] - r[0] - r[8], r[5] + r[7]};
    end else begin
      vec = '{r[3] - r[1], r[2] + r[6], r[5] + r[7], one_l + r[8] - r[0] - r[4]};
    end
    top = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (vec[i] < 0) ? longint'(-vec[i]) : longint'(vec[i]);
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      p.quat = '{0, 0, 0, 32'(one_l)};
      return p;
    end
    while (top >= (64'd1 << 31)) begin
      top >>= 1;
      for (int i = 0; i < 4; i++) mag[i] >>= 1;
    end
    while (top < (64'd1 << 30)) begin
      top <<= 1;
      for (int i = 0; i < 4; i++) mag[i] <<= 1;
    end
    acc = 0;
    for (int i = 0; i < 4; i++) acc += mag[i] * mag[i];
    // Bitwise integer square root.
    root = 0;
    rem_x = acc;
    rbit = 64'd1 << 62;
    while (rbit > rem_x) rbit >>= 2;
    while (rbit != 0) begin
      if (rem_x >= root + rbit) begin
        rem_x -= root + rbit;
        root = (root >> 1) + rbit;
      end else begin
        root >>= 1;
      end
      rbit >>= 2;
    end
    if (root == 0) root = 1;
    for (int i = 0; i < 4; i++) begin
      q = (mag[i] * longint'(one_l) + (root >> 1)) / root;
      if (q > one_l) q = one_l;
      // vec is ordered w, x, y, z; quat is x, y, z, w.
      p.quat[(i + 3) % 4] = (vec[i] < 0) ? 32'(-longint'(q)) : 32'(q);
    end
    return p;
  endfunction

  class pose_scoreboard;
    pose_t pending_poses [$];
    int errors;

    function void note_transform(transform_t tf);
      pending_poses = {pending_poses, pose_of(tf)};
    endfunction

    function void check_pose(pose_t got);
      pose_t exp_p;
      string pos_names [3] = '{"pos_x", "pos_y", "pos_z"};
      string quat_names [4] = '{"quat_x", "quat_y", "quat_z", "quat_w"};
      if (pending_poses.size() == 0) begin
        $error("pose arrived with none expected");
        errors++;
        return;
      end
      exp_p = pending_poses.pop_front();
      for (int i = 0; i < 3; i++)
        if (got.pos[i] !== exp_p.pos[i]) begin
          $error("%s expected %0d actual %0d", pos_names[i], exp_p.pos[i], got.pos[i]);
          errors++;
        end
      for (int i = 0; i < 4; i++)
        if (got.quat[i] !== exp_p.quat[i]) begin
          $error("%s expected %0d actual %0d", quat_names[i], exp_p.quat[i], got.quat[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] in_r00, in_r01, in_r02, in_r10, in_r11, in_r12, in_r20, in_r21, in_r22;
  logic signed [31:0] in_tx_mm, in_ty_mm, in_tz_mm;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w;

  pose_scoreboard board = new();
  transform_t directed_set [$];
  bit sending_done = 0;
  bit long_hold = 0;
  int idle_cycles = 0;

  rotation_matrix_to_quaternion_unit u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'($urandom_range(0, 2) - 1);
      3: return 32'($signed($urandom_range(0, 1 << 31)) - (1 << 30));
      default: return 32'($urandom());
    endcase
  endfunction

  // Half the transforms have a dominant diagonal around a random axis, so every branch is reached.
  function automatic transform_t rand_transform();
    transform_t tf;
    int axis, mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++)
      tf.rot[i] = (mode == 0) ? rand_word() : 32'($signed($urandom_range(0, 1 << 31)) - (1 << 30));
    if (mode >= 2) begin
      axis = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++)
        tf.rot[i * 4] = (axis == 3 || axis == i)
                        ? (32'sd1 << 30) - 32'($urandom_range(0, 1 << 20))
                        : -(32'sd1 << 30) + 32'($urandom_range(0, 1 << 20));
    end
    for (int i = 0; i < 3; i++) tf.trans[i] = rand_word();
    return tf;
  endfunction

  task automatic send_transform(transform_t tf);
    {in_r00, in_r01, in_r02, in_r10, in_r11, in_r12, in_r20, in_r21, in_r22} =
      {tf.rot[0], tf.rot[1], tf.rot[2], tf.rot[3], tf.rot[4], tf.rot[5],
       tf.rot[6], tf.rot[7], tf.rot[8]};
    {in_tx_mm, in_ty_mm, in_tz_mm} = {tf.trans[0], tf.trans[1], tf.trans[2]};
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    board.note_transform(tf);
    @(negedge clk);
  endtask

  task automatic idle_gap(int cycles);
    in_valid = 0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic build_directed();
    transform_t tf;
    logic signed [31:0] one_w;
    logic signed [31:0] edges [6];
    one_w = 32'sd1 << ONE_SHIFT;
    edges = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 32'sd499};
    for (int k = 0; k < 6; k++) begin
      tf.rot = '{default: 0};
      tf.trans = '{edges[k], -edges[k], edges[(k + 1) % 6]};
      case (k)
        0: tf.rot = '{one_w, 0, 0, 0, one_w, 0, 0, 0, one_w};
        1: tf.rot = '{one_w, 0, 0, 0, -one_w, 0, 0, 0, -one_w};
        2: tf.rot = '{-one_w, 0, 0, 0, one_w, 0, 0, 0, -one_w};
        3: tf.rot = '{-one_w, 0, 0, 0, -one_w, 0, 0, 0, one_w};
        4: tf.rot = '{default: 32'sh8000_0000};
        5: tf.rot = '{default: 32'sh7fff_ffff};
        default: tf.rot = '{default: 0};
      endcase
      directed_set = {directed_set, tf};
    end
    // Zero trace with all diagonals equal, and rounding ties of the position.
    tf.rot = '{0, -one_w, 0, one_w, 0, 0, 0, 0, 0};
    tf.trans = '{32'sd500, -32'sd500, 32'sd1500};
    directed_set = {directed_set, tf};
    tf.rot = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0,
               32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
    tf.trans = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh5555_5555};
    directed_set = {directed_set, tf};
    tf.rot = '{-32'sd1, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd1,
               32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, -32'sd2};
    tf.trans = '{32'shaaaa_aaaa, 32'sd999, -32'sd1};
    directed_set = {directed_set, tf};
  endtask

  // Sender.
  initial begin
    in_valid = 0;
    {in_r00, in_r01, in_r02, in_r10, in_r11, in_r12, in_r20, in_r21, in_r22} = '0;
    {in_tx_mm, in_ty_mm, in_tz_mm} = '0;
    rst_n = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    build_directed();
    foreach (directed_set[i]) send_transform(directed_set[i]);
    idle_gap(3);
    for (int sent = 0; sent < N_RANDOM;) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < N_RANDOM; b++, sent++)
        send_transform(rand_transform());
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 6));
    end
    in_valid = 0;
    sending_done = 1;
  end

  // Receiver stall pattern, with one long hold-off early on.
  initial begin
    out_stall = 0;
    @(posedge rst_n);
    repeat (40) @(negedge clk);
    long_hold = 1;
    out_stall = 1;
    repeat (300) @(negedge clk);
    out_stall = 0;
    long_hold = 0;
    forever begin
      int phase_len;
      phase_len = $urandom_range(5, 60);
      case ($urandom_range(0, 2))
        0: repeat (phase_len) @(negedge clk);
        1: repeat (phase_len) begin
             out_stall = ($urandom_range(0, 3) == 0);
             @(negedge clk);
           end
        default: repeat (phase_len) begin
             out_stall = ($urandom_range(0, 1) == 1);
             @(negedge clk);
           end
      endcase
      out_stall = 0;
    end
  end

  // Output sampling, watchdog and end of run.
  initial begin
    pose_t got;
    int settle;
    settle = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.pos = '{out_pos_x, out_pos_y, out_pos_z};
        got.quat = '{out_quat_x, out_quat_y, out_quat_z, out_quat_w};
        board.check_pose(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || long_hold)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (sending_done && board.pending_poses.size() == 0) settle++;
      if (settle >= DRAIN_WAIT) begin
        if (board.errors == 0)
          $display("Regression PASS");
        else
          $display("Regression FAIL");
        $finish;
      end
    end
  end
endmodule

/* rotation_matrix_to_quaternion_unit.f */
rtl/core/rmq_pkg.sv
rtl/core/rotation_matrix_to_quaternion_unit.sv
sim/testbench.sv
